@@ rtl/jac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick conditioner package
// Shared types and codes for the axis and button conditioner.
// ----------------------------------------------------------------------------
package jac_pkg;

	typedef enum logic [2:0] {
		OP_AXIS,
		OP_BUTTON,
		OP_CAL_ON,
		OP_CAL_OFF,
		OP_LOAD
	} op_t;

	localparam logic [2:0] KIND_AXIS    = 3'd0;
	localparam logic [2:0] KIND_BUTTON  = 3'd1;
	localparam logic [2:0] KIND_CAL_ON  = 3'd2;
	localparam logic [2:0] KIND_CAL_OFF = 3'd3;
	localparam logic [2:0] KIND_LOAD    = 3'd4;

	localparam logic [1:0] EV_AXIS    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	localparam logic [1:0] CFG_HAT  = 2'd0;
	localparam logic [1:0] CFG_REV  = 2'd1;
	localparam logic [1:0] CFG_DEAD = 2'd2;
	localparam logic [1:0] CFG_BTN  = 2'd3;

	localparam logic [14:0] Q_ONE      = 15'd16384;
	localparam logic [14:0] DEAD_RESET = 15'd2621;
	localparam logic [4:0]  BCNT_RESET = 5'd16;

	typedef struct packed {
		op_t         op;
		logic [2:0]  axis;
		logic [7:0]  raw;
		logic [7:0]  rmin;
		logic [7:0]  rmax;
		logic [15:0] word;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  hat_mask;
		logic [7:0]  rev_mask;
		logic [14:0] dead_zone;
		logic [4:0]  button_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  index;
		logic [15:0] value;
		logic        last;
	} event_t;

endpackage

@@ rtl/jac_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick conditioner command queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module jac_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jac_pkg::cmd_t wr_data,
	input  logic          pop,
	output jac_pkg::cmd_t rd_data,
	output logic          full,
	output logic          empty
);
	import jac_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/jac_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick conditioner front
// Accepts input words, decodes their kind and queues the ones that act.
// ----------------------------------------------------------------------------
module jac_front #(
	parameter int AXES = 8
) (
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [47:0]   s_tdata,
	input  logic [2:0]    s_tuser,
	input  logic          q_full,
	output logic          q_push,
	output jac_pkg::cmd_t q_data
);
	import jac_pkg::*;

	localparam logic [4:0] AXIS_LIM = 5'(AXES);

	logic axis_ok;
	logic keep;

	assign axis_ok = ({2'b00, s_tdata[2:0]} < AXIS_LIM);

	always_comb begin
		q_data.axis = s_tdata[2:0];
		q_data.raw  = s_tdata[10:3];
		q_data.rmin = s_tdata[18:11];
		q_data.rmax = s_tdata[26:19];
		q_data.word = s_tdata[42:27];
		q_data.op   = OP_AXIS;
		keep        = 1'b0;
		unique case (s_tuser)
			KIND_AXIS: begin
				q_data.op = OP_AXIS;
				keep      = axis_ok;
			end
			KIND_BUTTON: begin
				q_data.op = OP_BUTTON;
				keep      = 1'b1;
			end
			KIND_CAL_ON: begin
				q_data.op = OP_CAL_ON;
				keep      = 1'b1;
			end
			KIND_CAL_OFF: begin
				q_data.op = OP_CAL_OFF;
				keep      = 1'b1;
			end
			KIND_LOAD: begin
				q_data.op = OP_LOAD;
				keep      = axis_ok;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && keep;

endmodule

@@ rtl/jac_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick conditioner divider
// Restoring divider, one quotient bit per cycle, fifteen bits per run.
// ----------------------------------------------------------------------------
module jac_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [22:0] num,
	input  logic [8:0]  den,
	output logic        done,
	output logic [14:0] quot
);
	import jac_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [8:0]  rem_q;
	logic [8:0]  den_q;
	logic [14:0] sh_q;
	logic [9:0]  trial;
	logic        ge;

	assign trial = {rem_q, sh_q[14]};
	assign ge    = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
			rem_q  <= 9'd0;
			den_q  <= 9'd0;
			sh_q   <= 15'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 4'd0;
				rem_q <= {1'b0, num[22:15]};
				sh_q  <= num[14:0];
				den_q <= den;
			end else if (run_q) begin
				rem_q <= ge ? 9'(trial - {1'b0, den_q}) : trial[8:0];
				sh_q  <= {sh_q[13:0], ge};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd14) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/jac_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick conditioner back
// Executes queued commands: calibration state, axis scaling, button walk.
// ----------------------------------------------------------------------------
module jac_back #(
	parameter int AXES    = 8,
	parameter int BUTTONS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  jac_pkg::cfg_t  cfg,
	input  jac_pkg::cmd_t  cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output jac_pkg::event_t ev
);
	import jac_pkg::*;

	localparam int         AXIS_W  = (AXES > 1) ? $clog2(AXES) : 1;
	localparam logic [4:0] BTN_LIM = 5'((BUTTONS < 16) ? BUTTONS : 16);

	typedef enum logic [2:0] {
		S_IDLE,
		S_AXCAL,
		S_AXSET,
		S_AXDIV,
		S_AXOUT,
		S_BTN
	} state_t;

	state_t      state_q;
	cmd_t        e_q;
	logic        cal_q;
	logic [7:0]  lo_q  [AXES];
	logic [7:0]  mid_q [AXES];
	logic [7:0]  hi_q  [AXES];
	logic [15:0] btn_q;
	logic [15:0] pend_q;
	logic [3:0]  bi_q;
	logic        hat_q;
	logic        neg_q;
	logic [14:0] mag_q;
	logic        out_valid_q;
	event_t      out_q;

	logic [AXIS_W-1:0] ai;
	logic [AXIS_W-1:0] hi_idx;
	logic [7:0]        lo;
	logic [7:0]        mid;
	logic [7:0]        hi;
	logic [7:0]        r;
	logic              hat;
	logic signed [10:0] hn;
	logic signed [8:0]  hd;
	logic [9:0]        an;
	logic [7:0]        ad;
	logic              neg;
	logic              zero;
	logic              sat;
	logic              div_start;
	logic              div_done;
	logic [14:0]       div_quot;
	logic [22:0]       div_num;
	logic [8:0]        div_den;
	logic              out_free;
	logic [14:0]       mag_k;
	logic [15:0]       mag16;
	logic [15:0]       axis_val;
	logic              flip;
	logic [4:0]        blim;
	logic [15:0]       bmask;
	logic [15:0]       pend_nxt;
	logic [8:0]        lsum;

	assign ai       = AXIS_W'(e_q.axis);
	assign hi_idx   = AXIS_W'(cmd.axis);
	assign lo       = lo_q[ai];
	assign mid      = mid_q[ai];
	assign hi       = hi_q[ai];
	assign r        = e_q.raw;
	assign hat      = cfg.hat_mask[e_q.axis];
	assign out_free = !out_valid_q || m_tready;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign m_tvalid = out_valid_q;
	assign ev       = out_q;
	assign lsum     = {1'b0, cmd.rmin} + {1'b0, cmd.rmax};

	always_comb begin
		hn   = $signed({2'b00, r, 1'b0}) - $signed({3'b000, lo}) - $signed({3'b000, hi});
		hd   = $signed({1'b0, hi}) - $signed({1'b0, lo});
		an   = 10'd0;
		ad   = 8'd0;
		neg  = 1'b0;
		zero = 1'b1;
		if (hat) begin
			zero = (hi == lo);
			an   = hn[10] ? 10'(-hn) : hn[9:0];
			ad   = hd[8] ? 8'(-hd) : hd[7:0];
			neg  = hn[10] ^ hd[8];
		end else if (r >= mid) begin
			zero = !(hi > mid);
			an   = {2'b00, 8'(r - mid)};
			ad   = 8'(hi - mid);
		end else begin
			zero = !(lo < mid);
			an   = {2'b00, 8'(mid - r)};
			ad   = 8'(mid - lo);
			neg  = 1'b1;
		end
		sat       = !zero && (an >= {2'b00, ad});
		div_num   = {an[7:0], 7'd0, ad};
		div_den   = {ad, 1'b0};
		div_start = (state_q == S_AXSET) && !zero && !sat;
	end

	always_comb begin
		mag_k    = (!hat_q && (mag_q < cfg.dead_zone)) ? 15'd0 : mag_q;
		mag16    = {1'b0, mag_k};
		flip     = neg_q ^ cfg.rev_mask[e_q.axis];
		axis_val = flip ? 16'(-mag16) : mag16;
		blim     = (cfg.button_count > BTN_LIM) ? BTN_LIM : cfg.button_count;
		for (int i = 0; i < 16; i++) begin
			bmask[i] = (5'(i) < blim);
		end
		pend_nxt = pend_q & ~(16'd1 << bi_q);
	end

	jac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			e_q         <= '0;
			cal_q       <= 1'b0;
			btn_q       <= 16'd0;
			pend_q      <= 16'd0;
			bi_q        <= 4'd0;
			hat_q       <= 1'b0;
			neg_q       <= 1'b0;
			mag_q       <= 15'd0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int a = 0; a < AXES; a++) begin
				lo_q[a]  <= 8'd0;
				mid_q[a] <= 8'd128;
				hi_q[a]  <= 8'd255;
			end
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						e_q <= cmd;
						unique case (cmd.op)
							OP_AXIS: begin
								state_q <= S_AXCAL;
							end
							OP_BUTTON: begin
								pend_q  <= (cmd.word ^ btn_q) & bmask;
								btn_q   <= cmd.word;
								bi_q    <= 4'd0;
								state_q <= S_BTN;
							end
							OP_CAL_ON: begin
								cal_q <= 1'b1;
								for (int a = 0; a < AXES; a++) begin
									lo_q[a]  <= 8'd255;
									mid_q[a] <= 8'd0;
									hi_q[a]  <= 8'd0;
								end
							end
							OP_CAL_OFF: begin
								cal_q <= 1'b0;
							end
							OP_LOAD: begin
								lo_q[hi_idx]  <= cmd.rmin;
								hi_q[hi_idx]  <= cmd.rmax;
								mid_q[hi_idx] <= lsum[8:1];
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_AXCAL: begin
					// widen the range and follow the sample while calibrating a non-hat axis
					if (cal_q && !hat) begin
						if (r > hi) begin
							hi_q[ai] <= r;
						end
						if (r < lo) begin
							lo_q[ai] <= r;
						end
						mid_q[ai] <= r;
					end
					state_q <= S_AXSET;
				end
				S_AXSET: begin
					hat_q <= hat;
					neg_q <= neg;
					if (zero) begin
						mag_q   <= 15'd0;
						state_q <= S_AXOUT;
					end else if (sat) begin
						mag_q   <= Q_ONE;
						state_q <= S_AXOUT;
					end else begin
						state_q <= S_AXDIV;
					end
				end
				S_AXDIV: begin
					if (div_done) begin
						mag_q   <= div_quot;
						state_q <= S_AXOUT;
					end
				end
				S_AXOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.kind  <= EV_AXIS;
						out_q.index <= {1'b0, e_q.axis};
						out_q.value <= axis_val;
						out_q.last  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_BTN: begin
					if (pend_q == 16'd0) begin
						state_q <= S_IDLE;
					end else if (pend_q[bi_q]) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_q.kind  <= btn_q[bi_q] ? EV_PRESS : EV_RELEASE;
							out_q.index <= bi_q;
							out_q.value <= 16'd0;
							out_q.last  <= (pend_nxt == 16'd0);
							pend_q      <= pend_nxt;
							bi_q        <= bi_q + 4'd1;
						end
					end else begin
						bi_q <= bi_q + 4'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/joystick_axis_and_button_conditioner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis and button conditioner
// Calibrates and scales raw axis bytes to Q1.14 and turns button words into
// press and release events.
// ----------------------------------------------------------------------------
// Input words arrive on s_t*; s_tuser carries the kind. Output events leave on
// m_t*; m_tuser carries the event kind and m_tlast marks the final event of
// one input word. Registers are written on the cfg port; the user must write
// them only while the block idles, as the block itself does not enforce it.
// A two-entry queue parts the decoder from the executing back end.
// An axis sample passes from acceptance to its event through the queue, the
// calibration update, setup, a serial divider, its result handoff and the
// output stage; a zero or saturated value skips the divider.
// A button word walks bit positions up to the highest changed button.
// Calibration and range loads finish in the cycle they leave the queue.
// Reset clears the queue and the output register, restores the default
// ranges (0, 128, 255), the register defaults and the button state.
// A stalled receiver holds the output register; the back end waits and the
// queue keeps taking words until it holds two.
// ----------------------------------------------------------------------------
module joystick_axis_and_button_conditioner #(
	parameter int AXES    = 8,
	parameter int BUTTONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // axis_index, raw_value, range_min, range_max, button_word
	input  logic [2:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // event_index, axis_value
	output logic [1:0]  m_tuser,  // event_kind
	output logic        m_tlast
);
	import jac_pkg::*;

	cfg_t   cfg_q;
	cmd_t   push_data;
	cmd_t   head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;
	event_t ev;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hat_mask     <= 8'd0;
			cfg_q.rev_mask     <= 8'd0;
			cfg_q.dead_zone    <= DEAD_RESET;
			cfg_q.button_count <= BCNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HAT:  cfg_q.hat_mask     <= cfg_data[7:0];
				CFG_REV:  cfg_q.rev_mask     <= cfg_data[7:0];
				CFG_DEAD: cfg_q.dead_zone    <= cfg_data;
				CFG_BTN:  cfg_q.button_count <= cfg_data[4:0];
				default:  cfg_q.hat_mask     <= cfg_q.hat_mask;
			endcase
		end
	end

	jac_front #(
		.AXES (AXES)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (push),
		.q_data   (push_data)
	);

	jac_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	jac_back #(
		.AXES    (AXES),
		.BUTTONS (BUTTONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (head),
		.cmd_valid (!q_empty),
		.cmd_pop   (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.ev        (ev)
	);

	assign m_tdata = {4'd0, ev.value, ev.index};
	assign m_tuser = ev.kind;
	assign m_tlast = ev.last;

`ifndef SYNTH
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_AXIS) |->
		(($signed(m_tdata[19:4]) <= 16'sd16384) && ($signed(m_tdata[19:4]) >= -16'sd16384)))
		else $error("axis value out of range");

	a_button_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != EV_AXIS) |-> (m_tdata[19:4] == 16'd0))
		else $error("button event carries a value");

	a_axis_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_AXIS) |-> m_tlast)
		else $error("axis event not marked last");
`endif

endmodule

@@ bench/tb_joystick_axis_and_button_conditioner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick conditioner testbench
// Drives axis samples, button words, calibration commands and range loads into
// the conditioner under several register settings and random stalls on both
// streams. Every output event is checked in order against fixed expected values
// or a local model of the axis scaling, dead zone and button edge logic.
// ----------------------------------------------------------------------------
module tb_joystick_axis_and_button_conditioner;
	import jac_pkg::*;

	localparam int NUM_AXES   = 8;
	localparam int CYCLE_CAP  = 400000;
	localparam int SETTLE     = 40;
	localparam int PHASES     = 6;
	localparam int PER_PHASE  = 64;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  axis;
		logic [7:0]  raw;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [15:0] word;
	} stick_in_t;

	typedef struct packed {
		stick_in_t item;
		logic      typed;
		event_t    ev;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // axis_index, raw_value, range_min, range_max, button_word
	logic [2:0]  s_tuser = '0;  // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // event_index, axis_value
	logic [1:0]  m_tuser;       // event_kind
	logic        m_tlast;

	joystick_axis_and_button_conditioner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// model state and register copies
	logic [7:0]  cal_low  [NUM_AXES];
	logic [7:0]  cal_mid  [NUM_AXES];
	logic [7:0]  cal_high [NUM_AXES];
	logic        cal_on;
	logic [15:0] btn_now;
	logic [7:0]  hat_bits;
	logic [7:0]  rev_bits;
	logic [14:0] dz_level;
	logic [4:0]  btn_limit;

	event_t      events_due [$];
	event_t      fresh_events [$];
	row_t        plan [$];

	int          src_idle_pct = 27;
	int          sink_idle_pct = 51;
	int          errors = 0;
	int          words_sent = 0;
	int          events_seen = 0;
	int          cycle_count = 0;

	event_t      got_ev;
	event_t      want_ev;

	function automatic void reset_model();
		for (int a = 0; a < NUM_AXES; a++) begin
			cal_low[a]  = 8'd0;
			cal_mid[a]  = 8'd128;
			cal_high[a] = 8'd255;
		end
		cal_on    = 1'b0;
		btn_now   = '0;
		hat_bits  = '0;
		rev_bits  = '0;
		dz_level  = DEAD_RESET;
		btn_limit = BCNT_RESET;
	endfunction

	function automatic int q14_quot(int n, int d);
		bit     neg;
		longint an;
		longint ad;
		longint mag;
		neg = (n < 0) != (d < 0);
		an  = n < 0 ? -longint'(n) : longint'(n);
		ad  = d < 0 ? -longint'(d) : longint'(d);
		if (ad == 0)
			return 0;
		mag = (an * 2 * 16384 + ad) / (2 * ad);
		if (mag > 16384)
			mag = 16384;
		return neg ? -int'(mag) : int'(mag);
	endfunction

	function automatic int scale_axis(int a, int r);
		bit hat;
		int lo;
		int mid;
		int hi;
		int v;
		hat = hat_bits[a];
		v = 0;
		if (cal_on && !hat) begin
			if (r > cal_high[a])
				cal_high[a] = r[7:0];
			if (r < cal_low[a])
				cal_low[a] = r[7:0];
			cal_mid[a] = r[7:0];
		end
		lo  = cal_low[a];
		mid = cal_mid[a];
		hi  = cal_high[a];
		if (!hat) begin
			if (r >= mid) begin
				if (hi != mid) begin
					v = q14_quot(r - mid, hi - mid);
					if (v < 0)
						v = 0;
				end
			end else if (lo != mid) begin
				v = -q14_quot(r - mid, lo - mid);
				if (v > 0)
					v = 0;
			end
			if ((v < 0 ? -v : v) < int'(dz_level))
				v = 0;
		end else if (hi != lo) begin
			v = q14_quot(2 * (r - lo) - (hi - lo), hi - lo);
		end
		if (rev_bits[a])
			v = -v;
		return v;
	endfunction

	function automatic void condition_word(stick_in_t it);
		event_t e;
		int     lim;
		int     v;
		fresh_events.delete();
		case (it.kind)
			KIND_AXIS: begin
				v = scale_axis(int'(it.axis), int'(it.raw));
				e.kind  = EV_AXIS;
				e.index = {1'b0, it.axis};
				e.value = v[15:0];
				e.last  = 1'b1;
				fresh_events.push_back(e);
			end
			KIND_BUTTON: begin
				lim = btn_limit > 16 ? 16 : int'(btn_limit);
				for (int i = 0; i < lim; i++) begin
					if (btn_now[i] != it.word[i]) begin
						e.kind  = btn_now[i] ? EV_RELEASE : EV_PRESS;
						e.index = i[3:0];
						e.value = '0;
						e.last  = 1'b0;
						fresh_events.push_back(e);
					end
				end
				if (fresh_events.size() > 0)
					fresh_events[fresh_events.size() - 1].last = 1'b1;
				btn_now = it.word;
			end
			KIND_CAL_ON: begin
				cal_on = 1'b1;
				for (int a = 0; a < NUM_AXES; a++) begin
					cal_low[a]  = 8'd255;
					cal_high[a] = 8'd0;
					cal_mid[a]  = 8'd0;
				end
			end
			KIND_CAL_OFF: cal_on = 1'b0;
			KIND_LOAD: begin
				cal_low[it.axis]  = it.lo;
				cal_high[it.axis] = it.hi;
				cal_mid[it.axis]  = 8'((9'(it.lo) + 9'(it.hi)) >> 1);
			end
			default: ;
		endcase
	endfunction

	task automatic add_row(input logic [2:0] kind, input logic [2:0] axis,
			input logic [7:0] raw, input logic [7:0] lo, input logic [7:0] hi,
			input logic [15:0] word, input bit typed = 1'b0,
			input logic [1:0] ek = EV_AXIS, input logic [3:0] ei = '0,
			input int ev = 0);
		row_t r;
		r.item     = '{kind, axis, raw, lo, hi, word};
		r.typed    = typed;
		r.ev.kind  = ek;
		r.ev.index = ei;
		r.ev.value = ev[15:0];
		r.ev.last  = 1'b1;
		plan.push_back(r);
	endtask

	task automatic push_word(input stick_in_t it, input bit typed, input event_t typed_ev);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {5'b0, it.word, it.hi, it.lo, it.raw, it.axis};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		condition_word(it);
		if (typed)
			events_due.push_back(typed_ev);
		else
			foreach (fresh_events[k])
				events_due.push_back(fresh_events[k]);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_HAT:  hat_bits  = data[7:0];
			CFG_REV:  rev_bits  = data[7:0];
			CFG_DEAD: dz_level  = data;
			CFG_BTN:  btn_limit = data[4:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_word(output stick_in_t it);
		int pick;
		pick = $urandom_range(99);
		it.axis = 3'($urandom_range(7));
		it.raw  = 8'($urandom_range(255));
		it.lo   = 8'($urandom_range(255));
		it.hi   = 8'($urandom_range(255));
		it.word = 16'($urandom_range(16'hFFFF));
		if (pick < 45) begin
			it.kind = KIND_AXIS;
			if ($urandom_range(4) == 0)
				it.raw = $urandom_range(1) ? 8'd255 : 8'd0;
		end else if (pick < 70) begin
			it.kind = KIND_BUTTON;
			if ($urandom_range(1)) begin
				it.word = btn_now;
				repeat ($urandom_range(3)) it.word[$urandom_range(15)] ^= 1'b1;
			end
		end else if (pick < 80) begin
			it.kind = KIND_LOAD;
			if ($urandom_range(2) != 0 && it.lo > it.hi)
				{it.lo, it.hi} = {it.hi, it.lo};
		end else if (pick < 85) begin
			it.kind = KIND_CAL_ON;
		end else if (pick < 93) begin
			it.kind = KIND_CAL_OFF;
		end else begin
			it.kind = 3'(KIND_LOAD + 1 + $urandom_range(2));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_ev.kind  = m_tuser;
			got_ev.index = m_tdata[3:0];
			got_ev.value = m_tdata[19:4];
			got_ev.last  = m_tlast;
			events_seen++;
			if (events_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected event kind %0d index %0d value %0d last %0d",
					$realtime, got_ev.kind, got_ev.index, $signed(got_ev.value),
					got_ev.last);
			end else begin
				want_ev = events_due.pop_front();
				if (got_ev !== want_ev) begin
					errors++;
					$display("%0t: expected kind %0d index %0d value %0d last %0d, got %0d %0d %0d %0d",
						$realtime, want_ev.kind, want_ev.index, $signed(want_ev.value),
						want_ev.last, got_ev.kind, got_ev.index, $signed(got_ev.value),
						got_ev.last);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("%0t: timeout with %0d events outstanding", $realtime, events_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		stick_in_t it;
		event_t    none;
		int        counted;
		none = '0;
		reset_model();

		add_row(KIND_AXIS, 3'd0, 8'd255, 8'h00, 8'h00, 16'h0000, 1'b1, EV_AXIS, 4'd0, 16384);
		add_row(KIND_AXIS, 3'd0, 8'd0, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, EV_AXIS, 4'd0, -16384);
		add_row(KIND_AXIS, 3'd7, 8'd128, 8'h00, 8'h00, 16'h0000, 1'b1, EV_AXIS, 4'd7, 0);
		add_row(KIND_AXIS, 3'd3, 8'd200, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_BUTTON, 3'd0, 8'd0, 8'h00, 8'h00, 16'hFFFF);
		add_row(KIND_BUTTON, 3'd7, 8'd255, 8'hFF, 8'hFF, 16'hFFFF);
		add_row(KIND_BUTTON, 3'd0, 8'd0, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_BUTTON, 3'd0, 8'd0, 8'h00, 8'h00, 16'h8000, 1'b1, EV_PRESS, 4'd15, 0);
		add_row(KIND_BUTTON, 3'd0, 8'd0, 8'h00, 8'h00, 16'h0001);
		add_row(3'(KIND_LOAD + 1), 3'd2, 8'd77, 8'h12, 8'h34, 16'h5A5A);
		add_row(3'(KIND_LOAD + 3), 3'd7, 8'd255, 8'hFF, 8'hFF, 16'hFFFF);
		// zero span on both sides
		add_row(KIND_LOAD, 3'd2, 8'd0, 8'd10, 8'd10, 16'h0000);
		add_row(KIND_AXIS, 3'd2, 8'd10, 8'h00, 8'h00, 16'h0000, 1'b1, EV_AXIS, 4'd2, 0);
		add_row(KIND_AXIS, 3'd2, 8'd5, 8'h00, 8'h00, 16'h0000, 1'b1, EV_AXIS, 4'd2, 0);
		// inverted range, then a plain range on axis 5
		add_row(KIND_LOAD, 3'd1, 8'd0, 8'd200, 8'd50, 16'h0000);
		add_row(KIND_AXIS, 3'd1, 8'd130, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_AXIS, 3'd1, 8'd100, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_LOAD, 3'd5, 8'd0, 8'd20, 8'd220, 16'h0000);
		add_row(KIND_AXIS, 3'd5, 8'd255, 8'h00, 8'h00, 16'h0000);
		// calibration sweep
		add_row(KIND_CAL_ON, 3'd0, 8'd0, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_AXIS, 3'd0, 8'd100, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_AXIS, 3'd0, 8'd200, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_AXIS, 3'd0, 8'd40, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_CAL_OFF, 3'd0, 8'd0, 8'h00, 8'h00, 16'h0000);
		add_row(KIND_AXIS, 3'd0, 8'd150, 8'h00, 8'h00, 16'h0000);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r])
			push_word(plan[r].item, plan[r].typed, plan[r].ev);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin
					write_reg(CFG_HAT, 15'h00);
					write_reg(CFG_REV, 15'h00);
					write_reg(CFG_DEAD, 15'd0);
					write_reg(CFG_BTN, 15'd16);
				end
				1: begin
					write_reg(CFG_HAT, 15'hFF);
					write_reg(CFG_REV, 15'hFF);
					write_reg(CFG_DEAD, 15'd16384);
					write_reg(CFG_BTN, 15'd0);
				end
				2: begin
					write_reg(CFG_HAT, 15'h0F);
					write_reg(CFG_REV, 15'hA5);
					write_reg(CFG_DEAD, 15'h7FFF);
					write_reg(CFG_BTN, 15'd31);
				end
				4: begin
					write_reg(CFG_HAT, 15'hAA);
					write_reg(CFG_REV, 15'h55);
					write_reg(CFG_DEAD, 15'd1);
					write_reg(CFG_BTN, 15'd5);
				end
				default: begin
					write_reg(CFG_HAT, 15'($urandom_range(255)));
					write_reg(CFG_REV, 15'($urandom_range(255)));
					write_reg(CFG_DEAD, 15'($urandom_range(3000)));
					write_reg(CFG_BTN, 15'($urandom_range(31)));
				end
			endcase
			cfg_valid <= 1'b0;
			src_idle_pct  = p < 2 ? 27 : (p < 4 ? 51 : 0);
			sink_idle_pct = p < 2 ? 51 : (p < 4 ? 27 : 0);
			counted = 0;
			while (counted < PER_PHASE) begin
				random_word(it);
				if (it.kind <= KIND_LOAD)
					counted++;
				push_word(it, 1'b0, none);
			end
		end

		drain();
		$display("Sent %0d input words and checked %0d events across %0d register settings,",
			words_sent, events_seen, PHASES + 1);
		$display("with calibration, range loads, hat and reversed axes and button edges.");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
rtl/jac_pkg.sv
rtl/jac_fifo.sv
rtl/jac_front.sv
rtl/jac_div.sv
rtl/jac_back.sv
rtl/joystick_axis_and_button_conditioner.sv
bench/tb_joystick_axis_and_button_conditioner.sv
